### rtl/lkv_pkg.sv
// shared constants and types for the lru key-value cache
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 16;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]      rank_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CAP_W-1:0]      cap_t;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } match_t;

  typedef struct packed {
    logic wr_key;
    logic wr_val;
    idx_t slot;
  } upd_t;

endpackage

### rtl/lkv_match.sv
// parallel key compare across all entries with hit index encode
module lkv_match (
  input  logic [lkv_pkg::ENTRIES-1:0]              valid_i,
  input  lkv_pkg::key_t [lkv_pkg::ENTRIES-1:0]     keys_i,
  input  lkv_pkg::key_t                            key_i,
  output lkv_pkg::match_t                          match_o
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] hit_vec;

  // valid keys are unique, so at most one bit of hit_vec is set
  always_comb begin
    match_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_i[i] && (keys_i[i] == key_i);
      if (hit_vec[i]) begin
        match_o.idx = match_o.idx | IDX_W'(i);
      end
    end
    match_o.hit = |hit_vec;
  end

endmodule

### rtl/lkv_repl.sv
// recency rank update, victim choice and free slot choice
module lkv_repl (
  input  logic                                   req_vld_i,
  input  lkv_pkg::func_e                         func_i,
  input  lkv_pkg::match_t                        match_i,
  input  logic [lkv_pkg::ENTRIES-1:0]            valid_i,
  input  lkv_pkg::rank_t [lkv_pkg::ENTRIES-1:0]  ranks_i,
  input  lkv_pkg::cnt_t                          count_i,
  input  lkv_pkg::cap_t                          cap_i,
  output logic [lkv_pkg::ENTRIES-1:0]            valid_d_o,
  output lkv_pkg::rank_t [lkv_pkg::ENTRIES-1:0]  ranks_d_o,
  output lkv_pkg::cnt_t                          count_d_o,
  output lkv_pkg::upd_t                          upd_o
);
  import lkv_pkg::*;

  logic [CMP_W-1:0]   eff_cap;
  logic               evict;
  rank_t              hit_rank;
  rank_t              last_rank;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] kept;
  logic               free_ok;
  idx_t               free_slot;

  always_comb begin
    hit_rank  = ranks_i[match_i.idx];
    eff_cap   = (CMP_W'(cap_i) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_i);
    if (eff_cap == '0) begin
      eff_cap = CMP_W'(1);
    end
    evict     = (CMP_W'(count_i) >= eff_cap);
    // valid ranks are always a permutation of 0 .. count-1
    last_rank = IDX_W'(count_i - CNT_W'(1));

    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = evict && valid_i[i] && (ranks_i[i] == last_rank);
    end
    kept = valid_i & ~victim_oh;

    free_ok   = 1'b0;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!kept[i]) begin
        free_ok   = 1'b1;
        free_slot = IDX_W'(i);
      end
    end

    valid_d_o = valid_i;
    ranks_d_o = ranks_i;
    count_d_o = count_i;
    upd_o     = '0;

    if (req_vld_i) begin
      if (match_i.hit) begin
        // hit: entries more recent than the hit age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_i[i] && (ranks_i[i] < hit_rank)) begin
            ranks_d_o[i] = ranks_i[i] + 1'b1;
          end
        end
        ranks_d_o[match_i.idx] = '0;
        if (func_i == FUNC_PUT) begin
          upd_o.wr_val = 1'b1;
          upd_o.slot   = match_i.idx;
        end
      end else if (func_i == FUNC_PUT) begin
        // miss on put: evict if full, then insert as most recent
        valid_d_o = kept;
        count_d_o = count_i - CNT_W'(|victim_oh);
        for (int i = 0; i < ENTRIES; i++) begin
          if (victim_oh[i]) begin
            ranks_d_o[i] = '0;
          end
        end
        if (free_ok) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (kept[i]) begin
              ranks_d_o[i] = ranks_i[i] + 1'b1;
            end
          end
          ranks_d_o[free_slot] = '0;
          valid_d_o[free_slot] = 1'b1;
          count_d_o            = count_d_o + CNT_W'(1);
          upd_o.wr_key         = 1'b1;
          upd_o.wr_val         = 1'b1;
          upd_o.slot           = free_slot;
        end
      end
    end
  end

endmodule

### rtl/lru_key_value_cache_unit.sv
// top level of the fully associative lru key-value cache
// One request (get or put) is taken in every clock cycle: busy_o stays low and
// start_i may be held high on consecutive cycles. A request is registered at the
// edge where it is taken and looked up against all entries in the next cycle,
// which also updates the recency ranks; a get's result is then registered, sits
// on done_o, found_o and read_value_o for one cycle only and cannot be stalled by
// the receiver. Puts give no result. A request sees every earlier request's
// effect. A miss returns found_o low and read_value_o zero. Capacity is loaded
// through cfg_we_i / cfg_wdata_i; the user must load it only while no request is
// in flight, which the block does not enforce. Values above 16 act as 16 and zero
// acts as 1. Reset empties the cache.
module lru_key_value_cache_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                func_i,
  input  logic signed [lkv_pkg::KEY_BITS-1:0]   key_i,
  input  logic signed [lkv_pkg::VALUE_BITS-1:0] value_i,
  input  logic                                cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic signed [lkv_pkg::VALUE_BITS-1:0] read_value_o
);
  import lkv_pkg::*;

  // request register
  logic  req_vld_q;
  func_e func_q;
  key_t  key_q;
  val_t  value_q;

  // cache state
  logic [ENTRIES-1:0]  valid_q, valid_d;
  rank_t [ENTRIES-1:0] ranks_q, ranks_d;
  cnt_t                count_q, count_d;
  cap_t                cap_q;
  key_t                keys_q [ENTRIES];
  val_t                vals_q [ENTRIES];
  key_t [ENTRIES-1:0]  keys_flat;

  // result register
  logic done_q;
  logic found_q;
  val_t read_value_q;

  match_t match;
  upd_t   upd;
  logic   accept;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      keys_flat[i] = keys_q[i];
    end
  end

  lkv_match u_match (
    .valid_i (valid_q),
    .keys_i  (keys_flat),
    .key_i   (key_q),
    .match_o (match)
  );

  lkv_repl u_repl (
    .req_vld_i (req_vld_q),
    .func_i    (func_q),
    .match_i   (match),
    .valid_i   (valid_q),
    .ranks_i   (ranks_q),
    .count_i   (count_q),
    .cap_i     (cap_q),
    .valid_d_o (valid_d),
    .ranks_d_o (ranks_d),
    .count_d_o (count_d),
    .upd_o     (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      done_q    <= 1'b0;
      valid_q   <= '0;
      ranks_q   <= '0;
      count_q   <= '0;
      cap_q     <= CAP_W'(CAP_RESET);
    end else begin
      req_vld_q <= accept;
      done_q    <= req_vld_q && (func_q == FUNC_GET);
      valid_q   <= valid_d;
      ranks_q   <= ranks_d;
      count_q   <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_e'(func_i);
      key_q   <= key_t'(key_i);
      value_q <= val_t'(value_i);
    end
    if (upd.wr_key) begin
      keys_q[upd.slot] <= key_q;
    end
    if (upd.wr_val) begin
      vals_q[upd.slot] <= value_q;
    end
    if (req_vld_q) begin
      found_q      <= match.hit;
      read_value_q <= match.hit ? vals_q[match.idx] : '0;
    end
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

endmodule

### rtl/lkv_checker.sv
// port-level checker for the lru key-value cache and its bind
module lkv_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start_i,
  input logic                                  busy_o,
  input logic                                  func_i,
  input logic signed [lkv_pkg::KEY_BITS-1:0]   key_i,
  input logic signed [lkv_pkg::VALUE_BITS-1:0] value_i,
  input logic                                  cfg_we_i,
  input logic [lkv_pkg::CAP_W-1:0]             cfg_wdata_i,
  input logic                                  done_o,
  input logic                                  found_o,
  input logic signed [lkv_pkg::VALUE_BITS-1:0] read_value_o
);
  import lkv_pkg::*;

  // every get transfer is followed by a result on done_o
  a_get_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (func_i == FUNC_GET) |-> ##2 done_o)
    else $error("get transfer gave no result");

  // a put transfer gives no result
  a_put_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (func_i == FUNC_PUT) |-> ##2 !done_o)
    else $error("put transfer gave a result");

  // miss reads as zero
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> (read_value_o == '0))
    else $error("miss with non-zero value");

  // get right after a put of the same key hits with the stored value
  a_put_get : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FUNC_PUT)) ##1
    (start_i && !busy_o && (func_i == FUNC_GET) && (key_i == $past(key_i)))
    |-> ##2 (found_o && (read_value_o == $past(value_i, 3))))
    else $error("put then get of same key did not hit");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);
